// ===== hdl/fabt_pkg.sv =====
// ----------------------------------------------------------------------------
// fabt_pkg: shared types and constants of the failed-attempt ban table
// Operation codes, register indexes, hash constants, command/status structs.
// ----------------------------------------------------------------------------
package fabt_pkg;

	localparam int unsigned BUCKETS_DEF = 16;
	localparam int unsigned WAYS_DEF    = 4;

	localparam logic [1:0] OP_CHECK   = 2'd0;
	localparam logic [1:0] OP_FAIL    = 2'd1;
	localparam logic [1:0] OP_SUCCESS = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	localparam logic [0:0] REG_FAIL_LIMIT  = 1'd0;
	localparam logic [0:0] REG_BAN_SECONDS = 1'd1;

	localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd5;
	localparam logic [15:0] BAN_SECONDS_RST = 16'd300;

	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request
		logic hash_step;  // one FNV byte round
		logic mod_step;   // one byte of the bucket reduction
		logic prune_rd;   // issue prune read at sweep index
		logic prune_wr;   // evaluate prune read data
		logic way_rd;     // issue bucket read at way index
		logic way_eval;   // evaluate way read data
		logic commit;     // apply the operation to the chosen slot
		logic tick;       // advance seconds
	} fabt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_last;
		logic mod_last;
		logic sweep_last;
		logic way_last;
	} fabt_sts_t;

endpackage

// ===== hdl/fabt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fabt_ctrl: sequencer of the ban table
// Steps hashing, the bucket reduction, the expiry sweep, the bucket scan and the commit or the tick.
// ----------------------------------------------------------------------------
module fabt_ctrl import fabt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  logic       out_free,
	output logic       res_load,
	output fabt_cmd_t  cmd,
	input  fabt_sts_t  sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_SWEVL = 3'd4;
	localparam logic [2:0] S_WAY   = 3'd5;
	localparam logic [2:0] S_WEVL  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_CHECK;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) op_q <= in_op;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_op == OP_TICK) ? S_DONE : S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) state_d = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = (op_q == OP_CHECK) ? S_SWEEP : S_WAY;
				end
			end
			S_SWEEP: begin
				cmd.prune_rd = 1'b1;
				state_d      = S_SWEVL;
			end
			S_SWEVL: begin
				cmd.prune_wr = 1'b1;
				if (sts.sweep_last) state_d = S_WAY;
				else begin
					cmd.prune_rd = 1'b1;
				end
			end
			S_WAY: begin
				cmd.way_rd = 1'b1;
				state_d    = S_WEVL;
			end
			S_WEVL: begin
				cmd.way_eval = 1'b1;
				if (sts.way_last) state_d = S_DONE;
				else cmd.way_rd = 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					if (op_q == OP_TICK) cmd.tick = 1'b1;
					else cmd.commit = 1'b1;
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/fabt_dpath.sv =====
// ----------------------------------------------------------------------------
// fabt_dpath: hash, table memories and result logic of the ban table
// Holds the entry store, the seconds clock and the per-request scan state.
// ----------------------------------------------------------------------------
module fabt_dpath import fabt_pkg::*; #(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned WAYS    = WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fabt_cmd_t   cmd,
	output fabt_sts_t   sts,
	input  logic [1:0]  in_op,
	input  logic [31:0] in_address,
	input  logic [7:0]  fail_limit_q,
	input  logic [15:0] ban_seconds_q,
	output logic        res_banned,
	output logic [7:0]  res_failures,
	output logic        res_status
);

	localparam int unsigned SLOTS = BUCKETS * WAYS;
	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	// reciprocal for the bytewise bucket reduction: exact for x < 2^XW
	localparam int unsigned LB = $clog2(BUCKETS);
	localparam int unsigned XW = BW + 8;
	localparam int unsigned RS = XW + LB;
	localparam logic [63:0] RM = ((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

	// valid bits in flops; payload in memories
	logic [SLOTS-1:0] valid_q;
	logic [31:0] key_mem   [SLOTS];
	logic [7:0]  fails_mem [SLOTS];
	logic [31:0] until_mem [SLOTS];

	logic [1:0]    op_q;
	logic [31:0]   addr_q, hash_q, now_q;
	logic [1:0]    byte_q, dig_q;
	logic [BW-1:0] rem_q;
	logic [SW-1:0] ridx_q, eidx_q;
	logic [31:0]   rkey_q, runtil_q;
	logic [7:0]    rfails_q;
	logic          rvalid_q;
	logic [WW:0]   way_q;
	logic          hit_q, free_ok_q;
	logic [SW-1:0] hit_idx_q, free_idx_q;
	logic [7:0]    hit_fails_q;
	logic [31:0]   hit_until_q;
	logic [31:0]   hash_mul;
	logic [7:0]    hbyte, dbyte;
	logic [XW-1:0] red_x, red_quot, red_r;
	logic [63:0]   red_p;
	logic [SW-1:0] way_idx, rd_idx;

	// one FNV-1a round per cycle, most significant byte first
	always_comb begin
		unique case (byte_q)
			2'd0: hbyte = addr_q[31:24];
			2'd1: hbyte = addr_q[23:16];
			2'd2: hbyte = addr_q[15:8];
			default: hbyte = addr_q[7:0];
		endcase
	end
	assign hash_mul = (hash_q ^ {24'd0, hbyte}) * FNV_PRIME;

	// hash modulo BUCKETS, one byte per cycle: rem = (rem*256 + byte) mod BUCKETS
	always_comb begin
		unique case (dig_q)
			2'd0: dbyte = hash_q[31:24];
			2'd1: dbyte = hash_q[23:16];
			2'd2: dbyte = hash_q[15:8];
			default: dbyte = hash_q[7:0];
		endcase
	end
	assign red_x    = {rem_q, dbyte};
	assign red_p    = 64'(red_x) * RM;
	assign red_quot = XW'(red_p >> RS);
	assign red_r    = red_x - XW'(red_quot * BUCKETS);

	assign way_idx = SW'(rem_q * WAYS) + SW'(way_q);
	assign rd_idx  = cmd.way_rd ? way_idx : ridx_q;

	assign sts.hash_last  = (byte_q == 2'd3);
	assign sts.mod_last   = (dig_q == 2'd3);
	assign sts.sweep_last = (eidx_q == SW'(SLOTS - 1));
	assign sts.way_last   = (way_q == (WW+1)'(WAYS));

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			dig_q  <= '0;
			rem_q  <= '0;
			ridx_q <= '0;
			way_q  <= '0;
			hit_q  <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				byte_q <= '0;
				dig_q  <= '0;
				rem_q  <= '0;
				ridx_q <= '0;
				way_q  <= '0;
				hit_q  <= 1'b0;
				free_ok_q <= 1'b0;
			end
			if (cmd.hash_step) byte_q <= byte_q + 2'd1;
			if (cmd.mod_step) begin
				dig_q <= dig_q + 2'd1;
				rem_q <= BW'(red_r);
			end
			if (cmd.prune_rd) ridx_q <= ridx_q + SW'(1);
			if (cmd.way_rd) way_q <= way_q + (WW+1)'(1);
			if (cmd.way_eval) begin
				if (rvalid_q && rkey_q == addr_q && !hit_q) begin
					hit_q     <= 1'b1;
				end
				if (!rvalid_q && !free_ok_q) begin
					free_ok_q <= 1'b1;
				end
			end
		end
	end

	// request capture, hash and per-read payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			addr_q <= in_address;
			hash_q <= FNV_OFFSET;
		end
		if (cmd.hash_step) hash_q <= hash_mul;
		if (cmd.prune_rd || cmd.way_rd) begin
			eidx_q   <= rd_idx;
			rvalid_q <= valid_q[rd_idx];
			rkey_q   <= key_mem[rd_idx];
			rfails_q <= fails_mem[rd_idx];
			runtil_q <= until_mem[rd_idx];
		end
		if (cmd.way_eval) begin
			if (rvalid_q && rkey_q == addr_q && !hit_q) begin
				hit_idx_q   <= eidx_q;
				hit_fails_q <= rfails_q;
				hit_until_q <= runtil_q;
			end
			if (!rvalid_q && !free_ok_q) free_idx_q <= eidx_q;
		end
	end

	// commit arithmetic
	logic          found, fail_op, upd;
	logic [SW-1:0] slot;
	logic [7:0]    old_f, new_f;
	logic [31:0]   old_u, new_u, exp_new;
	logic          arm;

	assign found   = hit_q;
	assign fail_op = (op_q == OP_FAIL);
	assign slot    = found ? hit_idx_q : free_idx_q;
	assign upd     = found || free_ok_q;
	assign old_f   = found ? hit_fails_q : 8'd0;
	assign old_u   = found ? hit_until_q : 32'd0;
	assign new_f   = (old_f == 8'hFF) ? old_f : old_f + 8'd1;
	assign exp_new = now_q + {16'd0, ban_seconds_q};
	assign arm     = (new_f >= fail_limit_q);
	assign new_u   = arm ? exp_new : old_u;

	// table write, prune and seconds clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q   <= '0;
		end else begin
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.prune_wr && rvalid_q && runtil_q != 32'd0 && now_q >= runtil_q)
				valid_q[eidx_q] <= 1'b0;
			if (cmd.commit) begin
				if (fail_op && upd) valid_q[slot] <= 1'b1;
				if (op_q == OP_SUCCESS && found) valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && fail_op && upd) begin
			key_mem[slot]   <= addr_q;
			fails_mem[slot] <= new_f;
			until_mem[slot] <= new_u;
		end
	end

	// result fields
	always_comb begin
		res_banned   = 1'b0;
		res_failures = 8'd0;
		res_status   = 1'b0;
		case (op_q)
			OP_CHECK: begin
				if (found) begin
					res_failures = hit_fails_q;
					res_banned = (hit_until_q != 32'd0) && (now_q < hit_until_q);
				end
			end
			OP_FAIL: begin
				if (!upd) res_status = 1'b1;
				else begin
					res_failures = new_f;
					res_banned = (new_u != 32'd0) && (now_q < new_u);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/failed_attempt_ban_table.sv =====
// ----------------------------------------------------------------------------
// failed_attempt_ban_table: hashed failed-login ban list for IPv4 clients
// Top level: register file, output register, controller and datapath.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken the cycle after a result
// is loaded into the output register. A tick goes from acceptance straight to
// the final state; a failure or success takes 4 hash rounds, 4 bucket
// reduction rounds and a scan over the WAYS ways of its bucket; a check adds
// an expiry sweep over all BUCKETS*WAYS entries of the entry memory, one read
// a cycle. A result that cannot enter the output register, because the
// previous one is still held there, stalls the controller in its final state.
// No clearing pass after reset: entry valid bits are flip-flops.
module failed_attempt_ban_table import fabt_pkg::*; #(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned WAYS    = WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        banned,
	output logic [7:0]  failures,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_index,
	input  logic [31:0] cfg_data
);

	fabt_cmd_t   cmd;
	fabt_sts_t   sts;
	logic        res_load, r_banned, r_status;
	logic [7:0]  r_count;
	logic [7:0]  fail_limit_q;
	logic [15:0] ban_seconds_q;

	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q  <= FAIL_LIMIT_RST;
			ban_seconds_q <= BAN_SECONDS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == {31'd0, REG_FAIL_LIMIT}) fail_limit_q <= cfg_data[7:0];
			if (cfg_index == {31'd0, REG_BAN_SECONDS}) ban_seconds_q <= cfg_data[15:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) begin
			banned   <= r_banned;
			failures <= r_count;
			status   <= r_status;
		end
	end

	fabt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (op),
		.in_ready (in_ready),
		.out_free (!out_valid || out_ready),
		.res_load (res_load),
		.cmd      (cmd),
		.sts      (sts)
	);

	fabt_dpath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_op         (op),
		.in_address    (address),
		.fail_limit_q  (fail_limit_q),
		.ban_seconds_q (ban_seconds_q),
		.res_banned    (r_banned),
		.res_failures  (r_count),
		.res_status    (r_status)
	);

endmodule

// ===== hdl/fabt_checker.sv =====
// ----------------------------------------------------------------------------
// fabt_checker: port-level checks of the ban table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module fabt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       banned,
	input logic [7:0] failures,
	input logic       status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(failures))
		else $error("result changed while stalled");

	// a full bucket never reports a count or a ban
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !banned && failures == 8'd0)
		else $error("full bucket with payload");

	// a ban implies at least one recorded failure
	a_ban_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && banned |-> failures != 8'd0)
		else $error("ban without failures");

	// no new request taken in the cycle after one is taken
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back accept");

endmodule

bind failed_attempt_ban_table fabt_checker u_fabt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.banned    (banned),
	.failures  (failures),
	.status    (status)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the failed-attempt ban table
// Random checks, failures, successes and ticks over small address pools, under
// several register settings. Sender bursts and receiver stalls are random. Each
// result is checked field by field against a shadow table kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import fabt_pkg::*;

typedef struct {
	logic       banned;
	logic [7:0] failures;
	logic       status;
} ban_result_t;

// shadow copy of the ban table and the queue of results still owed
class ban_scoreboard;
	localparam int SLOTS = BUCKETS_DEF * WAYS_DEF;

	logic [7:0]  limit_q;
	logic [15:0] ban_len_q;
	logic        used[SLOTS];
	logic [31:0] key[SLOTS];
	logic [7:0]  fails[SLOTS];
	logic [31:0] expiry[SLOTS];
	logic [31:0] clock_s;
	ban_result_t owed[$];
	int          errors;

	function new();
		limit_q   = FAIL_LIMIT_RST;
		ban_len_q = BAN_SECONDS_RST;
		clock_s   = 0;
		errors    = 0;
		foreach (used[i]) used[i] = 1'b0;
	endfunction

	function automatic int bucket_base(logic [31:0] a);
		logic [31:0] h;
		h = 32'd2166136261;
		for (int i = 3; i >= 0; i--) h = (h ^ {24'd0, a[8*i +: 8]}) * 32'd16777619;
		return (h % BUCKETS_DEF) * WAYS_DEF;
	endfunction

	function automatic int find_entry(logic [31:0] a);
		int b;
		b = bucket_base(a);
		for (int w = 0; w < WAYS_DEF; w++)
			if (used[b + w] && key[b + w] == a) return b + w;
		return -1;
	endfunction

	function automatic logic ban_live(int s);
		return expiry[s] != 0 && clock_s < expiry[s];
	endfunction

	function void write_reg(logic [31:0] idx, logic [31:0] data);
		if (idx == 32'(REG_FAIL_LIMIT)) limit_q = data[7:0];
		else if (idx == 32'(REG_BAN_SECONDS)) ban_len_q = data[15:0];
	endfunction

	// an accepted request: update the shadow table and queue its result
	function void note_request(logic [1:0] o, logic [31:0] a);
		ban_result_t r;
		int s, b;
		r = '{1'b0, 8'd0, 1'b0};
		case (o)
			OP_CHECK: begin
				for (int i = 0; i < SLOTS; i++)
					if (used[i] && expiry[i] != 0 && clock_s >= expiry[i]) used[i] = 1'b0;
				s = find_entry(a);
				if (s >= 0) begin
					r.failures = fails[s];
					r.banned   = ban_live(s);
				end
			end
			OP_FAIL: begin
				s = find_entry(a);
				if (s < 0) begin
					b = bucket_base(a);
					for (int w = WAYS_DEF - 1; w >= 0; w--) if (!used[b + w]) s = b + w;
					if (s >= 0) begin
						used[s]   = 1'b1;
						key[s]    = a;
						fails[s]  = 0;
						expiry[s] = 0;
					end
				end
				if (s < 0) r.status = 1'b1;
				else begin
					if (fails[s] != 8'd255) fails[s]++;
					if (fails[s] >= limit_q) expiry[s] = clock_s + {16'd0, ban_len_q};
					r.failures = fails[s];
					r.banned   = ban_live(s);
				end
			end
			OP_SUCCESS: begin
				s = find_entry(a);
				if (s >= 0) used[s] = 1'b0;
			end
			default: clock_s++;
		endcase
		owed.push_back(r);
	endfunction

	function void check_result(logic bn, logic [7:0] fc, logic st);
		ban_result_t e;
		if (owed.size() == 0) begin
			$error("result with nothing outstanding");
			errors++;
			return;
		end
		e = owed.pop_front();
		if (bn !== e.banned) begin
			$error("banned: expected %0d, got %0d", e.banned, bn);
			errors++;
		end
		if (fc !== e.failures) begin
			$error("failures: expected %0d, got %0d", e.failures, fc);
			errors++;
		end
		if (st !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, st);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int          CYCLE_LIMIT = 3_000_000;
	localparam logic [31:0] REG_NONE    = 32'd2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_CHECK;
	logic [31:0] address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        banned;
	logic [7:0]  failures;
	logic        status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	ban_scoreboard ledger = new();
	int            cycles = 0;
	int            burst_left = 0;
	logic [31:0]   pool[8];

	failed_attempt_ban_table dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) ledger.check_result(banned, failures, status);

	// receiver stalls: runs of always-ready, coin-toss and long holds
	int stall_mode = 0, stall_run = 0;
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_run  = $urandom_range(5, 80);
		end
		stall_run--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// one request transaction; called at a falling edge, returns at one
	task automatic send_request(logic [1:0] o, logic [31:0] a);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op       <= o;
		address  <= a;
		do @(posedge clk); while (!in_ready);
		ledger.note_request(o, a);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.owed.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [31:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// random traffic over a fresh small pool of addresses
	task automatic random_phase(int count, int tick_pct);
		int pick;
		logic [1:0] o;
		logic [31:0] a;
		foreach (pool[i]) pool[i] = $urandom();
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < tick_pct) o = OP_TICK;
			else if (pick < tick_pct + 40) o = OP_FAIL;
			else if (pick < tick_pct + 70) o = OP_CHECK;
			else if (pick < tick_pct + 78) o = OP_SUCCESS;
			else o = 2'($urandom_range(0, 3));
			a = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
			send_request(o, a);
		end
	endtask

	initial begin
		logic [31:0] same[5];
		int n;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: address extremes, every operation, a full bucket
		send_request(OP_CHECK, 32'h0000_0000);
		send_request(OP_FAIL, 32'h0000_0000);
		send_request(OP_FAIL, 32'hFFFF_FFFF);
		send_request(OP_CHECK, 32'hFFFF_FFFF);
		send_request(OP_SUCCESS, 32'hFFFF_FFFF);
		send_request(OP_CHECK, 32'hFFFF_FFFF);
		send_request(OP_TICK, 32'hFFFF_FFFF);
		same[0] = $urandom();
		n = 1;
		while (n < 5) begin
			same[n] = $urandom();
			if (ledger.bucket_base(same[n]) == ledger.bucket_base(same[0]) &&
			    same[n] != same[0]) n++;
		end
		foreach (same[i]) send_request(OP_FAIL, same[i]);
		send_request(OP_SUCCESS, same[1]);
		send_request(OP_FAIL, same[4]);
		send_request(OP_CHECK, same[4]);
		repeat (5) send_request(OP_FAIL, same[0]);
		send_request(OP_CHECK, same[0]);
		random_phase(110, 10);
		drain();

		// short bans, limit of one, count saturation
		write_reg(REG_FAIL_LIMIT, 32'hFFFF_FF01);
		write_reg(REG_BAN_SECONDS, 32'd2);
		repeat (262) send_request(OP_FAIL, 32'h5A5A_A5A5);
		send_request(OP_CHECK, 32'h5A5A_A5A5);
		random_phase(110, 25);
		drain();

		// widest settings
		write_reg(REG_FAIL_LIMIT, 32'd255);
		write_reg(REG_BAN_SECONDS, 32'hFFFF_FFFF);
		random_phase(110, 15);
		drain();

		// zero limit and zero length: bans never live, pruned on check
		write_reg(REG_FAIL_LIMIT, 32'd0);
		write_reg(REG_BAN_SECONDS, 32'd0);
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		random_phase(110, 15);
		drain();

		write_reg(REG_FAIL_LIMIT, 32'd3);
		write_reg(REG_BAN_SECONDS, 32'd1);
		random_phase(110, 30);
		drain();

		write_reg(REG_FAIL_LIMIT, 32'd2);
		write_reg(REG_BAN_SECONDS, 32'd6);
		random_phase(110, 25);
		drain();

		repeat (200) @(posedge clk);
		if (ledger.errors == 0 && ledger.owed.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
